### rtl/core/twheel_pkg.sv
// Shared types, codes and widths for the timer wheel scheduler.
package twheel_pkg;

   localparam int TIMER_ENTRIES_DEF = 16;
   localparam int WHEEL_SLOTS_DEF   = 64;
   localparam int TIMEOUT_BITS_DEF  = 24;

   localparam int OPCODE_W    = 2;
   localparam int TIMEOUT_W   = 24;
   localparam int HANDLE_W    = 4;
   localparam int ENTRY_ID_W  = 4;
   localparam int STATUS_W    = 2;
   localparam int SLOT_OUT_W  = 6;
   localparam int ROT_OUT_W   = 24;
   localparam int SLOT_CNT_W  = 7;
   localparam int INTERVAL_W  = 16;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [SLOT_CNT_W-1:0] SLOT_COUNT_RST    = 7'd64;
   localparam logic [INTERVAL_W-1:0] TICK_INTERVAL_RST = 16'd1;

   localparam logic [OPCODE_W-1:0] OP_ADD  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_DEL  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_TICK = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd2;

   localparam logic REG_SLOT_COUNT    = 1'b0;
   localparam logic REG_TICK_INTERVAL = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIND,
      S_DIV_TICKS,
      S_DIV_ROUNDS,
      S_DIV_SLOT,
      S_ADD_OUT,
      S_FULL_OUT,
      S_DEL_OUT,
      S_SCAN_RD,
      S_SCAN_EV,
      S_FLUSH,
      S_ADV
   } state_type;

   typedef enum logic [1:0] {
      DIV_TICKS,
      DIV_ROUNDS,
      DIV_SLOT,
      DIV_POS
   } div_sel_type;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_ADD,
      EMIT_FULL,
      EMIT_DEL,
      EMIT_EMPTY,
      EMIT_PEND_LAST
   } emit_type;

   typedef struct packed {
      logic        accept;
      logic        scan_clear;
      logic        scan_next;
      logic        scan_eval;
      logic        alloc_take;
      logic        div_start;
      div_sel_type start_sel;
      logic        div_capture;
      div_sel_type cap_sel;
      emit_type    emit;
   } cmd_type;

   typedef struct packed {
      logic idx_free;
      logic idx_last;
      logic div_done;
      logic out_free;
      logic eval_emit;
      logic pend_valid;
   } sts_type;

endpackage

### rtl/core/timer_wheel_scheduler_top.sv
// Top level of the timer wheel scheduler: register port, controller and datapath.
// One request at a time; req_stall is high from acceptance until the request has finished,
//   which for a tick includes the wheel advance after its last result is queued.
// Add: free-entry search, then three divider runs.
// Tick: each entry is scanned in a read and an evaluate state, then one divider run advances the wheel.
// Sync reset clears all entries, the wheel position and the controller; slot_count -> 64,
//   tick_interval -> 1. No clearing pass.
module timer_wheel_scheduler_top #(
   parameter int TIMER_ENTRIES = twheel_pkg::TIMER_ENTRIES_DEF,
   parameter int WHEEL_SLOTS   = twheel_pkg::WHEEL_SLOTS_DEF,
   parameter int TIMEOUT_BITS  = twheel_pkg::TIMEOUT_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [twheel_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [twheel_pkg::TIMEOUT_W-1:0]     req_timeout,
   input  logic [twheel_pkg::HANDLE_W-1:0]      req_handle,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [twheel_pkg::ENTRY_ID_W-1:0]    rsp_entry_id,
   output logic [twheel_pkg::STATUS_W-1:0]      rsp_status,
   output logic                                 rsp_expired,
   output logic [twheel_pkg::SLOT_OUT_W-1:0]    rsp_assigned_slot,
   output logic [twheel_pkg::ROT_OUT_W-1:0]     rsp_assigned_rotation,
   output logic                                 rsp_last,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [twheel_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [twheel_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [twheel_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                 pready
);

   logic [twheel_pkg::SLOT_CNT_W-1:0] slot_count_ff;
   logic [twheel_pkg::INTERVAL_W-1:0] tick_interval_ff;
   logic                              csr_wr;
   twheel_pkg::cmd_type               cmd;
   twheel_pkg::sts_type               sts;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff    <= twheel_pkg::SLOT_COUNT_RST;
         tick_interval_ff <= twheel_pkg::TICK_INTERVAL_RST;
      end else if (csr_wr) begin
         if (paddr[2] == twheel_pkg::REG_SLOT_COUNT) begin
            slot_count_ff <= pwdata[twheel_pkg::SLOT_CNT_W-1:0];
         end else begin
            tick_interval_ff <= pwdata[twheel_pkg::INTERVAL_W-1:0];
         end
      end
   end

   assign prdata = (paddr[2] == twheel_pkg::REG_TICK_INTERVAL)
                   ? twheel_pkg::CSR_DATA_W'(tick_interval_ff)
                   : twheel_pkg::CSR_DATA_W'(slot_count_ff);

   twheel_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   twheel_dp #(
      .TIMER_ENTRIES (TIMER_ENTRIES),
      .WHEEL_SLOTS   (WHEEL_SLOTS),
      .TIMEOUT_BITS  (TIMEOUT_BITS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_timeout           (req_timeout),
      .req_handle            (req_handle),
      .slot_count            (slot_count_ff),
      .tick_interval         (tick_interval_ff),
      .rsp_stall             (rsp_stall),
      .rsp_valid             (rsp_valid),
      .rsp_entry_id          (rsp_entry_id),
      .rsp_status            (rsp_status),
      .rsp_expired           (rsp_expired),
      .rsp_assigned_slot     (rsp_assigned_slot),
      .rsp_assigned_rotation (rsp_assigned_rotation),
      .rsp_last              (rsp_last)
   );

endmodule

### rtl/core/twheel_ram.sv
// Generic single-write, single-read RAM with registered read data.
module twheel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/twheel_div.sv
// Restoring divider, one quotient bit per cycle.
module twheel_div #(
   parameter int DW = 24,
   parameter int VW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          busy,
   output logic          done,
   output logic [DW-1:0] quotient,
   output logic [VW-1:0] remainder
);

   localparam int CW = $clog2(DW + 1);

   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [DW-1:0] quot_ff;
   logic [VW-1:0] rem_ff;
   logic [VW-1:0] div_ff;
   logic [VW:0]   rem_sh;
   logic          fits;
   logic [VW-1:0] rem_in;
   logic [DW-1:0] quot_in;

   always_comb begin
      rem_sh  = {rem_ff, quot_ff[DW-1]};
      fits    = rem_sh >= {1'b0, div_ff};
      rem_in  = fits ? VW'(rem_sh - {1'b0, div_ff}) : VW'(rem_sh);
      quot_in = {quot_ff[DW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quot_ff <= dividend;
            rem_ff  <= '0;
            div_ff  <= divisor;
            cnt_ff  <= CW'(DW);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            quot_ff <= quot_in;
            rem_ff  <= rem_in;
            cnt_ff  <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

### rtl/core/twheel_ctrl.sv
// Controller state machine: sequences add, delete and tick requests.
module twheel_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic [twheel_pkg::OPCODE_W-1:0]     req_opcode,
   output logic                                req_stall,
   input  twheel_pkg::sts_type                 sts,
   output twheel_pkg::cmd_type                 cmd
);

   twheel_pkg::state_type state_ff;
   twheel_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= twheel_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.start_sel = twheel_pkg::DIV_TICKS;
      cmd.cap_sel   = twheel_pkg::DIV_TICKS;
      cmd.emit      = twheel_pkg::EMIT_NONE;
      req_stall     = (state_ff != twheel_pkg::S_IDLE);
      case (state_ff)
         twheel_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_opcode == twheel_pkg::OP_ADD) begin
                  cmd.scan_clear = 1'b1;
                  state_in       = twheel_pkg::S_FIND;
               end else if (req_opcode == twheel_pkg::OP_DEL) begin
                  state_in = twheel_pkg::S_DEL_OUT;
               end else if (req_opcode == twheel_pkg::OP_TICK) begin
                  cmd.scan_clear = 1'b1;
                  state_in       = twheel_pkg::S_SCAN_RD;
               end
            end
         end
         twheel_pkg::S_FIND: begin
            if (sts.idx_free) begin
               cmd.alloc_take = 1'b1;
               cmd.div_start  = 1'b1;
               cmd.start_sel  = twheel_pkg::DIV_TICKS;
               state_in       = twheel_pkg::S_DIV_TICKS;
            end else if (sts.idx_last) begin
               state_in = twheel_pkg::S_FULL_OUT;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         twheel_pkg::S_DIV_TICKS: begin
            if (sts.div_done) begin
               cmd.div_start = 1'b1;
               cmd.start_sel = twheel_pkg::DIV_ROUNDS;
               state_in      = twheel_pkg::S_DIV_ROUNDS;
            end
         end
         twheel_pkg::S_DIV_ROUNDS: begin
            if (sts.div_done) begin
               cmd.div_capture = 1'b1;
               cmd.cap_sel     = twheel_pkg::DIV_ROUNDS;
               cmd.div_start   = 1'b1;
               cmd.start_sel   = twheel_pkg::DIV_SLOT;
               state_in        = twheel_pkg::S_DIV_SLOT;
            end
         end
         twheel_pkg::S_DIV_SLOT: begin
            if (sts.div_done) begin
               cmd.div_capture = 1'b1;
               cmd.cap_sel     = twheel_pkg::DIV_SLOT;
               state_in        = twheel_pkg::S_ADD_OUT;
            end
         end
         twheel_pkg::S_ADD_OUT: begin
            if (sts.out_free) begin
               cmd.emit = twheel_pkg::EMIT_ADD;
               state_in = twheel_pkg::S_IDLE;
            end
         end
         twheel_pkg::S_FULL_OUT: begin
            if (sts.out_free) begin
               cmd.emit = twheel_pkg::EMIT_FULL;
               state_in = twheel_pkg::S_IDLE;
            end
         end
         twheel_pkg::S_DEL_OUT: begin
            if (sts.out_free) begin
               cmd.emit = twheel_pkg::EMIT_DEL;
               state_in = twheel_pkg::S_IDLE;
            end
         end
         twheel_pkg::S_SCAN_RD: begin
            state_in = twheel_pkg::S_SCAN_EV;
         end
         twheel_pkg::S_SCAN_EV: begin
            if (!(sts.eval_emit && !sts.out_free)) begin
               cmd.scan_eval = 1'b1;
               state_in = sts.idx_last ? twheel_pkg::S_FLUSH : twheel_pkg::S_SCAN_RD;
            end
         end
         twheel_pkg::S_FLUSH: begin
            if (sts.out_free) begin
               cmd.emit      = sts.pend_valid ? twheel_pkg::EMIT_PEND_LAST
                                              : twheel_pkg::EMIT_EMPTY;
               cmd.div_start = 1'b1;
               cmd.start_sel = twheel_pkg::DIV_POS;
               state_in      = twheel_pkg::S_ADV;
            end
         end
         twheel_pkg::S_ADV: begin
            if (sts.div_done) begin
               cmd.div_capture = 1'b1;
               cmd.cap_sel     = twheel_pkg::DIV_POS;
               state_in        = twheel_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = twheel_pkg::S_IDLE;
         end
      endcase
   end

endmodule

### rtl/core/twheel_dp.sv
// Datapath: entry pool, wheel position, divider and result register.
module twheel_dp #(
   parameter int TIMER_ENTRIES = twheel_pkg::TIMER_ENTRIES_DEF,
   parameter int WHEEL_SLOTS   = twheel_pkg::WHEEL_SLOTS_DEF,
   parameter int TIMEOUT_BITS  = twheel_pkg::TIMEOUT_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  twheel_pkg::cmd_type                  cmd,
   output twheel_pkg::sts_type                  sts,
   input  logic [twheel_pkg::TIMEOUT_W-1:0]     req_timeout,
   input  logic [twheel_pkg::HANDLE_W-1:0]      req_handle,
   input  logic [twheel_pkg::SLOT_CNT_W-1:0]    slot_count,
   input  logic [twheel_pkg::INTERVAL_W-1:0]    tick_interval,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [twheel_pkg::ENTRY_ID_W-1:0]    rsp_entry_id,
   output logic [twheel_pkg::STATUS_W-1:0]      rsp_status,
   output logic                                 rsp_expired,
   output logic [twheel_pkg::SLOT_OUT_W-1:0]    rsp_assigned_slot,
   output logic [twheel_pkg::ROT_OUT_W-1:0]     rsp_assigned_rotation,
   output logic                                 rsp_last
);

   localparam int IDX_W = $clog2(TIMER_ENTRIES);
   localparam int POS_W = $clog2(WHEEL_SLOTS);
   localparam int NSW   = $clog2(WHEEL_SLOTS + 1);
   localparam int DW    = (TIMEOUT_BITS > NSW + 1) ? TIMEOUT_BITS : NSW + 1;
   localparam int VW    = (twheel_pkg::INTERVAL_W > NSW) ? twheel_pkg::INTERVAL_W : NSW;
   localparam int RW    = POS_W + TIMEOUT_BITS;

   logic [TIMER_ENTRIES-1:0]   active_ff;
   logic [POS_W-1:0]           pos_ff;
   logic [IDX_W-1:0]           scan_idx_ff;
   logic [IDX_W-1:0]           alloc_ff;
   logic [IDX_W-1:0]           pend_ff;
   logic                       pend_valid_ff;
   logic [TIMEOUT_BITS-1:0]    timeout_ff;
   logic [twheel_pkg::HANDLE_W-1:0] handle_ff;
   logic [TIMEOUT_BITS-1:0]    rounds_ff;
   logic [POS_W-1:0]           slot_ff;

   logic                       rsp_valid_ff;
   logic [twheel_pkg::ENTRY_ID_W-1:0] rsp_entry_id_ff;
   logic [twheel_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic                       rsp_expired_ff;
   logic [twheel_pkg::SLOT_OUT_W-1:0] rsp_slot_ff;
   logic [twheel_pkg::ROT_OUT_W-1:0]  rsp_rot_ff;
   logic                       rsp_last_ff;

   logic [NSW-1:0]                  n_eff;
   logic [twheel_pkg::INTERVAL_W-1:0] iv_eff;
   logic                       div_busy;
   logic                       div_done;
   logic [DW-1:0]              div_q;
   logic [VW-1:0]              div_r;
   logic [DW-1:0]              div_dd;
   logic [VW-1:0]              div_dv;
   logic [DW-1:0]              ticks_now;

   logic                       ram_we;
   logic [IDX_W-1:0]           ram_waddr;
   logic [RW-1:0]              ram_wdata;
   logic [RW-1:0]              ram_rdata;
   logic [POS_W-1:0]           rd_slot;
   logic [TIMEOUT_BITS-1:0]    rd_rounds;

   logic                       hit;
   logic                       expire;
   logic                       eval_emit_now;
   logic [IDX_W-1:0]           hidx;
   logic                       handle_ok;
   logic                       out_free;

   always_comb begin
      if (slot_count == '0) begin
         n_eff = NSW'(1);
      end else if (32'(slot_count) > WHEEL_SLOTS) begin
         n_eff = NSW'(WHEEL_SLOTS);
      end else begin
         n_eff = NSW'(slot_count);
      end
      iv_eff    = (tick_interval == '0) ? twheel_pkg::INTERVAL_W'(1) : tick_interval;
      ticks_now = (div_q == '0) ? DW'(1) : div_q;
      case (cmd.start_sel)
         twheel_pkg::DIV_TICKS: begin
            div_dd = DW'(timeout_ff);
            div_dv = VW'(iv_eff);
         end
         twheel_pkg::DIV_ROUNDS: begin
            div_dd = ticks_now;
            div_dv = VW'(n_eff);
         end
         twheel_pkg::DIV_SLOT: begin
            div_dd = DW'(div_r) + DW'(pos_ff);
            div_dv = VW'(n_eff);
         end
         twheel_pkg::DIV_POS: begin
            div_dd = DW'(pos_ff) + DW'(1);
            div_dv = VW'(n_eff);
         end
         default: begin
            div_dd = '0;
            div_dv = VW'(1);
         end
      endcase
   end

   twheel_div #(
      .DW (DW),
      .VW (VW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dd),
      .divisor   (div_dv),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign rd_slot   = ram_rdata[RW-1:TIMEOUT_BITS];
   assign rd_rounds = ram_rdata[TIMEOUT_BITS-1:0];

   assign hit           = active_ff[scan_idx_ff] && (rd_slot == pos_ff);
   assign expire        = hit && (rd_rounds == '0);
   assign eval_emit_now = cmd.scan_eval && expire && pend_valid_ff;
   assign hidx          = IDX_W'(handle_ff);
   assign handle_ok     = (32'(handle_ff) < TIMER_ENTRIES) && active_ff[hidx];
   assign out_free      = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = scan_idx_ff;
      ram_wdata = {rd_slot, rd_rounds - TIMEOUT_BITS'(1)};
      if (cmd.emit == twheel_pkg::EMIT_ADD) begin
         ram_we    = 1'b1;
         ram_waddr = alloc_ff;
         ram_wdata = {slot_ff, rounds_ff};
      end else if (cmd.scan_eval && hit && !expire) begin
         ram_we = 1'b1;
      end
   end

   twheel_ram #(
      .WIDTH (RW),
      .DEPTH (TIMER_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (scan_idx_ff),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         pos_ff        <= '0;
         scan_idx_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.accept) begin
            timeout_ff <= TIMEOUT_BITS'(req_timeout);
            handle_ff  <= req_handle;
         end
         if (cmd.scan_clear) begin
            scan_idx_ff   <= '0;
            pend_valid_ff <= 1'b0;
         end else if (cmd.scan_next || cmd.scan_eval) begin
            scan_idx_ff <= scan_idx_ff + IDX_W'(1);
         end
         if (cmd.alloc_take) begin
            alloc_ff <= scan_idx_ff;
         end
         if (cmd.div_capture) begin
            case (cmd.cap_sel)
               twheel_pkg::DIV_ROUNDS: rounds_ff <= TIMEOUT_BITS'(div_q);
               twheel_pkg::DIV_SLOT:   slot_ff   <= POS_W'(div_r);
               twheel_pkg::DIV_POS:    pos_ff    <= POS_W'(div_r);
               default: ;
            endcase
         end
         if (cmd.scan_eval && expire) begin
            active_ff[scan_idx_ff] <= 1'b0;
            pend_ff                <= scan_idx_ff;
            pend_valid_ff          <= 1'b1;
         end
         if (eval_emit_now) begin
            rsp_valid_ff    <= 1'b1;
            rsp_entry_id_ff <= twheel_pkg::ENTRY_ID_W'(pend_ff);
            rsp_status_ff   <= twheel_pkg::STAT_OK;
            rsp_expired_ff  <= 1'b1;
            rsp_slot_ff     <= '0;
            rsp_rot_ff      <= '0;
            rsp_last_ff     <= 1'b0;
         end
         case (cmd.emit)
            twheel_pkg::EMIT_NONE: ;
            twheel_pkg::EMIT_ADD: begin
               active_ff[alloc_ff] <= 1'b1;
               rsp_valid_ff    <= 1'b1;
               rsp_entry_id_ff <= twheel_pkg::ENTRY_ID_W'(alloc_ff);
               rsp_status_ff   <= twheel_pkg::STAT_OK;
               rsp_expired_ff  <= 1'b0;
               rsp_slot_ff     <= twheel_pkg::SLOT_OUT_W'(slot_ff);
               rsp_rot_ff      <= twheel_pkg::ROT_OUT_W'(rounds_ff);
               rsp_last_ff     <= 1'b1;
            end
            twheel_pkg::EMIT_FULL: begin
               rsp_valid_ff    <= 1'b1;
               rsp_entry_id_ff <= '0;
               rsp_status_ff   <= twheel_pkg::STAT_FULL;
               rsp_expired_ff  <= 1'b0;
               rsp_slot_ff     <= '0;
               rsp_rot_ff      <= '0;
               rsp_last_ff     <= 1'b1;
            end
            twheel_pkg::EMIT_DEL: begin
               if (handle_ok) begin
                  active_ff[hidx] <= 1'b0;
               end
               rsp_valid_ff    <= 1'b1;
               rsp_entry_id_ff <= twheel_pkg::ENTRY_ID_W'(handle_ff);
               rsp_status_ff   <= handle_ok ? twheel_pkg::STAT_OK : twheel_pkg::STAT_BAD;
               rsp_expired_ff  <= 1'b0;
               rsp_slot_ff     <= '0;
               rsp_rot_ff      <= '0;
               rsp_last_ff     <= 1'b1;
            end
            twheel_pkg::EMIT_EMPTY: begin
               rsp_valid_ff    <= 1'b1;
               rsp_entry_id_ff <= '0;
               rsp_status_ff   <= twheel_pkg::STAT_OK;
               rsp_expired_ff  <= 1'b0;
               rsp_slot_ff     <= '0;
               rsp_rot_ff      <= '0;
               rsp_last_ff     <= 1'b1;
            end
            twheel_pkg::EMIT_PEND_LAST: begin
               rsp_valid_ff    <= 1'b1;
               rsp_entry_id_ff <= twheel_pkg::ENTRY_ID_W'(pend_ff);
               rsp_status_ff   <= twheel_pkg::STAT_OK;
               rsp_expired_ff  <= 1'b1;
               rsp_slot_ff     <= '0;
               rsp_rot_ff      <= '0;
               rsp_last_ff     <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      sts            = '0;
      sts.idx_free   = !active_ff[scan_idx_ff];
      sts.idx_last   = (scan_idx_ff == IDX_W'(TIMER_ENTRIES - 1));
      sts.div_done   = div_done;
      sts.out_free   = out_free;
      sts.eval_emit  = expire && pend_valid_ff;
      sts.pend_valid = pend_valid_ff;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_entry_id          = rsp_entry_id_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_expired           = rsp_expired_ff;
   assign rsp_assigned_slot     = rsp_slot_ff;
   assign rsp_assigned_rotation = rsp_rot_ff;
   assign rsp_last              = rsp_last_ff;

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider restarted while busy");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit != twheel_pkg::EMIT_NONE || eval_emit_now) |-> out_free)
      else $error("result register overwritten");

   a_alloc_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit == twheel_pkg::EMIT_ADD |-> !active_ff[alloc_ff])
      else $error("allocated entry already active");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit == twheel_pkg::EMIT_ADD |-> 32'(slot_ff) < 32'(n_eff))
      else $error("assigned slot beyond slot count");

endmodule

### bench/testbench.sv
// Self-checking testbench for the timer wheel scheduler: predicts every result and compares.
module testbench;

   typedef struct {
      logic [twheel_pkg::OPCODE_W-1:0]  opcode;
      logic [twheel_pkg::TIMEOUT_W-1:0] timeout;
      logic [twheel_pkg::HANDLE_W-1:0]  handle;
   } request_type;

   typedef struct {
      logic [twheel_pkg::ENTRY_ID_W-1:0] entry_id;
      logic [twheel_pkg::STATUS_W-1:0]   status;
      logic                              expired;
      logic [twheel_pkg::SLOT_OUT_W-1:0] slot;
      logic [twheel_pkg::ROT_OUT_W-1:0]  rotation;
      logic                              last;
   } result_type;

   localparam int ENTRIES = twheel_pkg::TIMER_ENTRIES_DEF;
   localparam int SLOTS   = twheel_pkg::WHEEL_SLOTS_DEF;
   localparam logic [twheel_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_done = 0;
   logic [twheel_pkg::OPCODE_W-1:0]  req_opcode = '0;
   logic [twheel_pkg::TIMEOUT_W-1:0] req_timeout = '0;
   logic [twheel_pkg::HANDLE_W-1:0]  req_handle = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [twheel_pkg::ENTRY_ID_W-1:0] rsp_entry_id;
   logic [twheel_pkg::STATUS_W-1:0]   rsp_status;
   logic                              rsp_expired;
   logic [twheel_pkg::SLOT_OUT_W-1:0] rsp_assigned_slot;
   logic [twheel_pkg::ROT_OUT_W-1:0]  rsp_assigned_rotation;
   logic                              rsp_last;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [twheel_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [twheel_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [twheel_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   request_type pending_requests[$];
   result_type  expected_results[$];
   int errors = 0;
   int results_seen = 0;
   int expiries_seen = 0;
   int requests_sent = 0;
   int driver_gap = 0;

   logic [twheel_pkg::SLOT_CNT_W-1:0] slot_count_reg;
   logic [twheel_pkg::INTERVAL_W-1:0] interval_reg;
   logic                  entry_busy[ENTRIES];
   logic [5:0]            entry_slot[ENTRIES];
   logic [23:0]           entry_rounds[ENTRIES];
   logic [5:0]            wheel_pos;

   timer_wheel_scheduler_top dut (.*);

   always #2 clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      errors++;
   endtask

   function automatic result_type make_result(int id, int st, bit ex, int sl, int rot, bit lst);
      result_type r;
      r.entry_id = twheel_pkg::ENTRY_ID_W'(id);
      r.status = twheel_pkg::STATUS_W'(st);
      r.expired = ex;
      r.slot = twheel_pkg::SLOT_OUT_W'(sl);
      r.rotation = twheel_pkg::ROT_OUT_W'(rot);
      r.last = lst;
      return r;
   endfunction

   function automatic void predict_wheel(request_type q);
      int n, found, cnt;
      longint iv, ticks;
      n = (slot_count_reg == 0) ? 1 : (slot_count_reg > SLOTS ? SLOTS : int'(slot_count_reg));
      iv = (interval_reg == 0) ? 1 : longint'(interval_reg);
      case (q.opcode)
         twheel_pkg::OP_ADD: begin
            found = -1;
            for (int i = ENTRIES - 1; i >= 0; i--)
               if (!entry_busy[i]) found = i;
            if (found < 0) begin
               expected_results.push_back(make_result(0, twheel_pkg::STAT_FULL, 0, 0, 0, 1));
            end else begin
               ticks = (q.timeout < iv) ? 1 : q.timeout / iv;
               entry_busy[found] = 1;
               entry_slot[found] = 6'((wheel_pos + ticks) % n);
               entry_rounds[found] = 24'(ticks / n);
               expected_results.push_back(make_result(found, twheel_pkg::STAT_OK, 0,
                  entry_slot[found], entry_rounds[found], 1));
            end
         end
         twheel_pkg::OP_DEL: begin
            if (entry_busy[q.handle]) begin
               entry_busy[q.handle] = 0;
               expected_results.push_back(make_result(q.handle, twheel_pkg::STAT_OK,
                  0, 0, 0, 1));
            end else begin
               expected_results.push_back(make_result(q.handle, twheel_pkg::STAT_BAD,
                  0, 0, 0, 1));
            end
         end
         twheel_pkg::OP_TICK: begin
            cnt = 0;
            for (int i = 0; i < ENTRIES; i++) begin
               if (entry_busy[i] && entry_slot[i] == wheel_pos) begin
                  if (entry_rounds[i] > 0) begin
                     entry_rounds[i]--;
                  end else begin
                     entry_busy[i] = 0;
                     expected_results.push_back(make_result(i, twheel_pkg::STAT_OK,
                        1, 0, 0, 0));
                     cnt++;
                  end
               end
            end
            if (cnt == 0) begin
               expected_results.push_back(make_result(0, twheel_pkg::STAT_OK, 0, 0, 0, 1));
            end else begin
               expected_results[$].last = 1;
            end
            wheel_pos = 6'((wheel_pos + 1) % n);
         end
         default: ;
      endcase
   endfunction

   function automatic int random_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_done <= 0;
      end else begin
         req_done <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            predict_wheel('{req_opcode, req_timeout, req_handle});
            requests_sent++;
         end
      end
   end

   always @(negedge clock) begin
      request_type q;
      if (reset) begin
         req_valid <= 0;
      end else if (req_valid && !req_done) begin
         // hold
      end else if (driver_gap > 0) begin
         driver_gap <= driver_gap - 1;
         req_valid <= 0;
      end else if (pending_requests.size() > 0) begin
         q = pending_requests.pop_front();
         req_valid <= 1;
         req_opcode <= q.opcode;
         req_timeout <= q.timeout;
         req_handle <= q.handle;
         driver_gap <= random_gap();
      end else begin
         req_valid <= 0;
      end
   end

   always @(negedge clock) begin
      if ($urandom_range(0, 19) == 0) rsp_stall <= 1;
      else if ($urandom_range(0, 2) == 0) rsp_stall <= 0;
      else if (!rsp_stall) rsp_stall <= $urandom_range(0, 3) == 0;
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_expired) expiries_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result entry_id", rsp_entry_id, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_entry_id !== want.entry_id)
               report_mismatch("entry_id", rsp_entry_id, want.entry_id);
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
            if (rsp_expired !== want.expired)
               report_mismatch("expired", rsp_expired, want.expired);
            if (rsp_assigned_slot !== want.slot)
               report_mismatch("assigned_slot", rsp_assigned_slot, want.slot);
            if (rsp_assigned_rotation !== want.rotation)
               report_mismatch("assigned_rotation", rsp_assigned_rotation, want.rotation);
            if (rsp_last !== want.last) report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   task automatic write_register(input logic idx, input int value);
      @(negedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
      @(negedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      if (idx == twheel_pkg::REG_SLOT_COUNT) slot_count_reg = twheel_pkg::SLOT_CNT_W'(value);
      else interval_reg = twheel_pkg::INTERVAL_W'(value);
   endtask

   task automatic queue_request(input logic [twheel_pkg::OPCODE_W-1:0] op, input int t,
                                input int h);
      request_type q;
      q.opcode = op;
      q.timeout = twheel_pkg::TIMEOUT_W'(t);
      q.handle = twheel_pkg::HANDLE_W'(h);
      pending_requests.push_back(q);
   endtask

   task automatic drain_wheel();
      while (pending_requests.size() > 0 || req_valid || req_stall ||
             expected_results.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_phase(input int count, input int max_timeout);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40) queue_request(twheel_pkg::OP_ADD, $urandom_range(0, max_timeout), 0);
         else if (r < 55) queue_request(twheel_pkg::OP_DEL, 0, $urandom_range(0, 15));
         else if (r < 97) queue_request(twheel_pkg::OP_TICK, $urandom, $urandom);
         else if (r < 98) queue_request(twheel_pkg::OP_ADD, $urandom, $urandom);
         else queue_request(OP_UNUSED, $urandom, $urandom);
      end
      drain_wheel();
   endtask

   initial begin
      slot_count_reg = twheel_pkg::SLOT_COUNT_RST;
      interval_reg = twheel_pkg::TICK_INTERVAL_RST;
      wheel_pos = 0;
      foreach (entry_busy[i]) begin
         entry_busy[i] = 0; entry_slot[i] = 0; entry_rounds[i] = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 0;
      write_register(twheel_pkg::REG_SLOT_COUNT, 4);
      write_register(twheel_pkg::REG_TICK_INTERVAL, 1);
      queue_request(twheel_pkg::OP_ADD, 0, 0);
      queue_request(twheel_pkg::OP_ADD, 24'hFFFFFF, 0);
      queue_request(twheel_pkg::OP_ADD, 3, 0);
      queue_request(twheel_pkg::OP_ADD, 4, 0);
      queue_request(twheel_pkg::OP_DEL, 0, 15);
      queue_request(twheel_pkg::OP_DEL, 0, 1);
      queue_request(twheel_pkg::OP_DEL, 0, 1);
      queue_request(OP_UNUSED, 24'hFFFFFF, 15);
      for (int i = 0; i < 6; i++) queue_request(twheel_pkg::OP_TICK, 0, 0);
      for (int i = 0; i < 15; i++) queue_request(twheel_pkg::OP_ADD, 1, 0);
      queue_request(twheel_pkg::OP_ADD, 5, 0);
      queue_request(twheel_pkg::OP_TICK, 0, 0);
      queue_request(twheel_pkg::OP_TICK, 0, 0);
      drain_wheel();
      random_phase(120, 40);
      write_register(twheel_pkg::REG_SLOT_COUNT, 1);
      write_register(twheel_pkg::REG_TICK_INTERVAL, 65535);
      random_phase(60, 24'hFFFFFF);
      write_register(twheel_pkg::REG_TICK_INTERVAL, 3);
      random_phase(60, 20);
      write_register(twheel_pkg::REG_SLOT_COUNT, 64);
      write_register(twheel_pkg::REG_TICK_INTERVAL, 2);
      random_phase(100, 300);
      write_register(twheel_pkg::REG_SLOT_COUNT, 0);
      write_register(twheel_pkg::REG_TICK_INTERVAL, 0);
      random_phase(40, 10);
      write_register(twheel_pkg::REG_SLOT_COUNT, 127);
      write_register(twheel_pkg::REG_TICK_INTERVAL, 16'hAAAA);
      random_phase(40, 24'hFFFFFF);
      write_register(twheel_pkg::REG_SLOT_COUNT, 7);
      write_register(twheel_pkg::REG_TICK_INTERVAL, 16'h5555);
      random_phase(80, 24'h3FFFF);
      $display("%0d requests sent, %0d results checked, %0d expiries.",
         requests_sent, results_seen, expiries_seen);
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end
endmodule
